// ----- src/rrms_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrms_pkg
// Shared widths, action codes and constants of the rotating range-min store.
// ----------------------------------------------------------------------------
package rrms_pkg;

    localparam int VAL_W = 30;
    localparam int POS_W = 10;
    localparam int MIN_W = 31;
    localparam int LEN_W = 11;
    localparam int ACT_W = 2;

    typedef logic [ACT_W-1:0] action_t;
    typedef logic [VAL_W-1:0] value_t;
    typedef logic [MIN_W-1:0] min_t;

    localparam action_t ACT_ROTATE = 2'd0;
    localparam action_t ACT_QUERY  = 2'd1;
    localparam action_t ACT_WRITE  = 2'd2;

    localparam min_t           EMPTY_MIN = 31'h4000_0000;
    localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

endpackage
`default_nettype wire

// ----- src/rrms_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrms_cell
// One storage cell of the circulating ring; takes the value on its input (its
// neighbor's, or the feed value for the tail cell) on every shift cycle.
// ----------------------------------------------------------------------------
module rrms_cell (
    input  wire logic            aclk,
    input  wire logic            shift_en,
    input  wire rrms_pkg::value_t data_in,
    output rrms_pkg::value_t      data_out
);
    import rrms_pkg::*;

    value_t data_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            data_reg <= data_in;
        end
    end

    assign data_out = data_reg;

endmodule
`default_nettype wire

// ----- src/rrms_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrms_ctrl
// Head cell sequencer: tracks the logical position at the ring head, applies
// writes, rotates and min accumulation as positions pass, owns the length
// register and the result register.
// ----------------------------------------------------------------------------
module rrms_ctrl #(
    parameter int DEPTH = 1024
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [rrms_pkg::LEN_W-1:0] cfg_data,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire rrms_pkg::action_t          s_action,
    input  wire logic [rrms_pkg::POS_W-1:0] s_left_pos,
    input  wire logic [rrms_pkg::POS_W-1:0] s_right_pos,
    input  wire rrms_pkg::value_t           s_new_value,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output rrms_pkg::min_t                  m_min_value,
    input  wire rrms_pkg::value_t           head_value,
    output rrms_pkg::value_t                feed_value,
    output logic                            shift_en
);
    import rrms_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);
    localparam int CW = (LW > LEN_W) ? LW : LEN_W;
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
    localparam logic [PW-1:0] LAST_POS = PW'(DEPTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WR_SEEK,
        ST_ROT_SEEK,
        ST_ROT_RUN,
        ST_QRY_RUN,
        ST_QRY_OUT
    } state_t;

    state_t           state_reg, state_next;
    logic [PW-1:0]    head_pos_reg, head_pos_next;
    logic [PW-1:0]    cnt_reg, cnt_next;
    logic [PW-1:0]    l_reg, l_next;
    logic [PW-1:0]    rc_reg, rc_next;
    value_t           val_reg, val_next;
    value_t           carry_reg, carry_next;
    value_t           capt_reg, capt_next;
    min_t             acc_reg, acc_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             m_valid_reg, m_valid_next;
    min_t             m_min_reg, m_min_next;

    logic [CW-1:0] len_eff, l_ext, r_ext, r_clip;
    logic          span_ok, wr_ok, accept, out_free;

    assign cfg_ready   = 1'b1;
    assign s_ready     = (state_reg == ST_IDLE);
    assign accept      = s_valid && s_ready;
    assign m_valid     = m_valid_reg;
    assign m_min_value = m_min_reg;
    assign out_free    = !m_valid_reg || m_ready;
    assign shift_en    = (state_reg == ST_WR_SEEK) || (state_reg == ST_ROT_SEEK) ||
                         (state_reg == ST_ROT_RUN) || (state_reg == ST_QRY_RUN);

    always_comb begin
        len_eff = (CW'(len_reg) < DEPTH_C) ? CW'(len_reg) : DEPTH_C;
        l_ext   = CW'(s_left_pos);
        r_ext   = CW'(s_right_pos);
        r_clip  = (r_ext >= len_eff) ? (len_eff - CW'(1)) : r_ext;
        span_ok = (len_eff != '0) && (l_ext < len_eff) && (l_ext <= r_clip);
        wr_ok   = (l_ext < len_eff);
    end

    always_comb begin
        state_next    = state_reg;
        head_pos_next = head_pos_reg;
        cnt_next      = cnt_reg;
        l_next        = l_reg;
        rc_next       = rc_reg;
        val_next      = val_reg;
        carry_next    = carry_reg;
        capt_next     = capt_reg;
        acc_next      = acc_reg;
        len_next      = len_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_min_next    = m_min_reg;
        feed_value    = head_value;

        if (cfg_valid && cfg_ready) begin
            len_next = cfg_data;
        end

        if (shift_en) begin
            head_pos_next = (head_pos_reg == LAST_POS) ? '0 : head_pos_reg + PW'(1);
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    l_next   = PW'(l_ext);
                    rc_next  = PW'(r_clip);
                    val_next = s_new_value;
                    cnt_next = '0;
                    acc_next = EMPTY_MIN;
                    unique case (s_action)
                        ACT_ROTATE: state_next = span_ok ? ST_ROT_SEEK : ST_IDLE;
                        ACT_QUERY:  state_next = span_ok ? ST_QRY_RUN : ST_QRY_OUT;
                        ACT_WRITE:  state_next = wr_ok ? ST_WR_SEEK : ST_IDLE;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WR_SEEK: begin
                if (head_pos_reg == l_reg) begin
                    feed_value = val_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_ROT_SEEK: begin
                if (head_pos_reg == rc_reg) begin
                    capt_next  = head_value;
                    state_next = ST_ROT_RUN;
                end
            end
            ST_ROT_RUN: begin
                if (head_pos_reg == l_reg) begin
                    feed_value = capt_reg;
                    carry_next = head_value;
                end else if (head_pos_reg > l_reg && head_pos_reg <= rc_reg) begin
                    feed_value = carry_reg;
                    carry_next = head_value;
                end
                if (head_pos_reg == rc_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_QRY_RUN: begin
                if (head_pos_reg >= l_reg && head_pos_reg <= rc_reg &&
                    {1'b0, head_value} < acc_reg) begin
                    acc_next = {1'b0, head_value};
                end
                cnt_next = cnt_reg + PW'(1);
                if (cnt_reg == LAST_POS) begin
                    state_next = ST_QRY_OUT;
                end
            end
            ST_QRY_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_min_next   = acc_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            head_pos_reg <= '0;
            cnt_reg      <= '0;
            len_reg      <= LEN_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_pos_reg <= head_pos_next;
            cnt_reg      <= cnt_next;
            len_reg      <= len_next;
            m_valid_reg  <= m_valid_next;
        end
        l_reg     <= l_next;
        rc_reg    <= rc_next;
        val_reg   <= val_next;
        carry_reg <= carry_next;
        capt_reg  <= capt_next;
        acc_reg   <= acc_next;
        m_min_reg <= m_min_next;
    end

    a_no_accept_while_shifting: assert property (
        @(posedge aclk) disable iff (!aresetn)
        shift_en |-> !s_ready
    ) else $error("input accepted while ring is busy");

    a_result_from_query: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg ##1 m_valid_reg) |-> $past(state_reg == ST_QRY_OUT)
    ) else $error("result beat raised outside query completion");

    a_result_bounded: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_min_reg <= EMPTY_MIN)
    ) else $error("result above empty sentinel");

    a_rotate_ends_at_right: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROT_RUN && head_pos_reg == rc_reg) |=> (state_reg == ST_IDLE)
    ) else $error("rotate did not finish at the right end");

    a_head_in_range: assert property (
        @(posedge aclk) disable iff (!aresetn)
        head_pos_reg <= LAST_POS
    ) else $error("head position out of range");

endmodule
`default_nettype wire

// ----- src/rotating_range_min_store.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rotating_range_min_store
// Sequence store with rotate, range-minimum query and write, built as a ring
// of DEPTH circulating cells with one processing head.
// ----------------------------------------------------------------------------
// The values sit in a ring of DEPTH cells that advances one position per
// cycle while an item is at work; all processing happens at the head cell,
// so item latency is set by how long the needed positions take to circulate
// past it. A write waits until its position reaches the head. A query
// circulates the whole ring before its result beat, and waits longer if the
// previous result is still unread. A rotate first waits for the right end
// to reach the head, then makes one full revolution. Items that do nothing
// (empty span, write beyond the length, unused action) go straight back to
// idle, and an empty query delivers 2^30 without circulating the ring. One
// item is in work at a time; the result register lets the next item start
// while a result beat waits. Stored values have no reset.
// ----------------------------------------------------------------------------
module rotating_range_min_store #(
    parameter int DEPTH = 1024
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [rrms_pkg::LEN_W-1:0] cfg_data,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire rrms_pkg::action_t          s_action,
    input  wire logic [rrms_pkg::POS_W-1:0] s_left_pos,
    input  wire logic [rrms_pkg::POS_W-1:0] s_right_pos,
    input  wire rrms_pkg::value_t           s_new_value,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output rrms_pkg::min_t                  m_min_value
);
    import rrms_pkg::*;

    value_t ring_q [DEPTH];
    value_t feed_value;
    logic   shift_en;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            if (gi == DEPTH - 1) begin : g_tail
                rrms_cell u_cell (
                    .aclk     (aclk),
                    .shift_en (shift_en),
                    .data_in  (feed_value),
                    .data_out (ring_q[gi])
                );
            end else begin : g_body
                rrms_cell u_cell (
                    .aclk     (aclk),
                    .shift_en (shift_en),
                    .data_in  (ring_q[gi+1]),
                    .data_out (ring_q[gi])
                );
            end
        end
    endgenerate

    rrms_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_left_pos  (s_left_pos),
        .s_right_pos (s_right_pos),
        .s_new_value (s_new_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_min_value (m_min_value),
        .head_value  (ring_q[0]),
        .feed_value  (feed_value),
        .shift_en    (shift_en)
    );

endmodule
`default_nettype wire

// ----- dv/tb_rotating_range_min_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rotating_range_min_store
// Drives write, rotate, query and unused-action beats into the store at
// several sequence lengths, predicts every query minimum from a shadow copy
// of the sequence, and checks each result beat against the oldest prediction.
// Both sides idle at random; the receiver also holds off for long stretches.
// ----------------------------------------------------------------------------
module tb_rotating_range_min_store;
    import rrms_pkg::*;

    localparam int          DEPTH        = 1024;
    localparam int          CLK_PERIOD   = 10;
    localparam int          DRAIN_CYCLES = 2 * DEPTH + 16;
    localparam int          LONG_HOLD    = 6000;
    localparam int          CYCLE_LIMIT  = 8_000_000;
    localparam int unsigned NO_HINT      = 32'hFFFF_FFFF;
    localparam action_t     ACT_NONE     = 2'd3;

    typedef struct {
        action_t            act;
        logic [POS_W-1:0]   lpos;
        logic [POS_W-1:0]   rpos;
        value_t             val;
        bit                 drain_first;
    } store_op_t;

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               cfg_valid   = 1'b0;
    logic               cfg_ready;
    logic [LEN_W-1:0]   cfg_data    = '0;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    action_t            s_action    = ACT_ROTATE;
    logic [POS_W-1:0]   s_left_pos  = '0;
    logic [POS_W-1:0]   s_right_pos = '0;
    value_t             s_new_value = '0;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    min_t               m_min_value;

    store_op_t          pending[$];
    min_t               expected_mins[$];
    value_t             shadow_seq [DEPTH];
    bit                 loaded_pos [DEPTH];
    logic [LEN_W-1:0]   seq_len     = LEN_RESET;
    int unsigned        n_expected  = 0;
    int unsigned        n_matched   = 0;
    int unsigned        n_fail      = 0;
    int unsigned        cycles      = 0;
    int unsigned        tx_gap      = 0;
    int unsigned        tx_calm     = 0;
    int unsigned        rx_gap      = 0;
    int unsigned        rx_calm     = 0;
    int unsigned        rx_hold     = 0;
    int unsigned        rx_beats    = 0;

    rotating_range_min_store #(
        .DEPTH(DEPTH)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_action   (s_action),
        .s_left_pos (s_left_pos),
        .s_right_pos(s_right_pos),
        .s_new_value(s_new_value),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_min_value(m_min_value)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL rotating_range_min_store");
            $finish;
        end
    end

    function automatic int unsigned eff_len();
        return (seq_len > DEPTH) ? DEPTH : seq_len;
    endfunction

    // mostly short gaps, a few long ones, now and then a run with none
    function automatic int unsigned idle_len(inout int unsigned calm);
        int unsigned r;
        if (calm != 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 64);
    endfunction

    task automatic step_sequence(input store_op_t op, output bit has_min, output min_t found);
        int unsigned n;
        int unsigned rc;
        int unsigned i;
        bit          span_ok;
        value_t      moved;
        has_min = 1'b0;
        found   = EMPTY_MIN;
        n       = eff_len();
        rc      = 0;
        if (n != 0) rc = (op.rpos >= n) ? n - 1 : op.rpos;
        span_ok = (n != 0) && (op.lpos < n) && (op.lpos <= rc);
        case (op.act)
            ACT_ROTATE: begin
                if (span_ok) begin
                    moved = shadow_seq[rc];
                    for (i = rc; i > op.lpos; i--) shadow_seq[i] = shadow_seq[i-1];
                    shadow_seq[op.lpos] = moved;
                end
            end
            ACT_QUERY: begin
                has_min = 1'b1;
                if (span_ok) begin
                    for (i = op.lpos; i <= rc; i++)
                        if (shadow_seq[i] < found) found = shadow_seq[i];
                end
            end
            ACT_WRITE: begin
                if (op.lpos < n) shadow_seq[op.lpos] = op.val;
            end
            default: ;
        endcase
    endtask

    // sender
    always @(posedge aclk) begin : send_ops
        store_op_t   cur_op;
        bit          got_min;
        min_t        want;
        int unsigned query_now;
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            query_now = 0;
            if (s_valid && s_ready) begin
                step_sequence(cur_op, got_min, want);
                if (got_min) begin
                    expected_mins.push_back(want);
                    n_expected <= n_expected + 1;
                    query_now = 1;
                end
            end
            if (!s_valid || s_ready) begin
                if (tx_gap != 0) begin
                    tx_gap--;
                    s_valid <= 1'b0;
                end else if (pending.size() != 0 &&
                             !(pending[0].drain_first &&
                               n_matched != n_expected + query_now)) begin
                    cur_op = pending.pop_front();
                    s_valid     <= 1'b1;
                    s_action    <= cur_op.act;
                    s_left_pos  <= cur_op.lpos;
                    s_right_pos <= cur_op.rpos;
                    s_new_value <= cur_op.val;
                    tx_gap = idle_len(tx_calm);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver, with a long hold-off every so often
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_gap   = 0;
            rx_hold  = 0;
            rx_beats = 0;
        end else if (rx_hold != 0) begin
            rx_hold--;
            m_ready <= (rx_hold == 0);
        end else if (rx_gap != 0) begin
            rx_gap--;
            m_ready <= (rx_gap == 0);
        end else if (m_valid && m_ready) begin
            rx_beats++;
            if (rx_beats % 150 == 25) begin
                rx_hold = LONG_HOLD;
                m_ready <= 1'b0;
            end else begin
                rx_gap = idle_len(rx_calm);
                m_ready <= (rx_gap == 0);
            end
        end else if ($urandom_range(0, 15) == 0) begin
            rx_gap = idle_len(rx_calm);
            m_ready <= (rx_gap == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_mins
        min_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_mins.size() == 0) begin
                $error("unexpected beat: min_value=%0d", m_min_value);
                n_fail++;
            end else begin
                want = expected_mins.pop_front();
                if (m_min_value !== want) begin
                    $error("min_value: expected %0d, actual %0d", want, m_min_value);
                    n_fail++;
                end
                n_matched <= n_matched + 1;
            end
        end
    end

    function automatic value_t rand_val();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return value_t'($urandom_range(0, 15));
            default: return value_t'($urandom());
        endcase
    endfunction

    task automatic queue_op(input action_t act, input int unsigned lpos,
                            input int unsigned rpos, input value_t val);
        store_op_t op;
        op.act         = act;
        op.lpos        = lpos[POS_W-1:0];
        op.rpos        = rpos[POS_W-1:0];
        op.val         = val;
        op.drain_first = ($urandom_range(0, 49) == 0);
        if (act == ACT_WRITE && lpos < eff_len()) loaded_pos[lpos] = 1'b1;
        pending.push_back(op);
    endtask

    // span inside a run of loaded positions; the right end may overshoot the length
    function automatic bit pick_span(input int unsigned hint, output int unsigned lo,
                                     output int unsigned hi);
        int unsigned n;
        int unsigned p;
        int unsigned a;
        int unsigned b;
        int unsigned rc;
        int unsigned tries;
        n     = eff_len();
        p     = hint;
        tries = 0;
        lo    = 0;
        hi    = 0;
        if (n == 0) return 1'b0;
        while ((p >= n || !loaded_pos[p]) && tries < 24) begin
            p = $urandom_range(0, n - 1);
            tries++;
        end
        if (p >= n || !loaded_pos[p]) return 1'b0;
        a = p;
        while (a > 0 && loaded_pos[a-1]) a--;
        b = p;
        while (b < n - 1 && loaded_pos[b+1]) b++;
        lo = $urandom_range(a, b);
        rc = $urandom_range(lo, b);
        hi = rc;
        if (rc == n - 1 && $urandom_range(0, 1) == 1) hi = $urandom_range(rc, DEPTH - 1);
        return 1'b1;
    endfunction

    function automatic action_t span_act();
        return ($urandom_range(0, 2) != 0) ? ACT_QUERY : ACT_ROTATE;
    endfunction

    task automatic queue_noise();
        int unsigned n;
        int unsigned l;
        n = eff_len();
        case ($urandom_range(0, 2))
            0: queue_op(ACT_NONE, $urandom_range(0, DEPTH - 1), $urandom_range(0, DEPTH - 1),
                        rand_val());
            1: begin
                if (n < DEPTH && $urandom_range(0, 1) == 1) begin
                    queue_op(span_act(), $urandom_range(n, DEPTH - 1),
                             $urandom_range(0, DEPTH - 1), rand_val());
                end else begin
                    l = $urandom_range(1, DEPTH - 1);
                    queue_op(span_act(), l, $urandom_range(0, l - 1), rand_val());
                end
            end
            default: begin
                if (n < DEPTH)
                    queue_op(ACT_WRITE, $urandom_range(n, DEPTH - 1),
                             $urandom_range(0, DEPTH - 1), rand_val());
                else
                    queue_op(ACT_WRITE, $urandom_range(0, DEPTH - 1),
                             $urandom_range(0, DEPTH - 1), rand_val());
            end
        endcase
    endtask

    task automatic gen_random(input int unsigned n_items);
        int unsigned made;
        int unsigned n;
        int unsigned pick;
        int unsigned start;
        int unsigned k;
        int unsigned i;
        int unsigned lo;
        int unsigned hi;
        made = 0;
        while (made < n_items) begin
            n    = eff_len();
            pick = $urandom_range(0, 99);
            if (n != 0 && pick < 45) begin
                // load a run, then work on it
                start = $urandom_range(0, n - 1);
                k     = $urandom_range(1, 12);
                for (i = start; i < start + k && i < n; i++) begin
                    queue_op(ACT_WRITE, i, $urandom_range(0, DEPTH - 1), rand_val());
                    made++;
                end
                k = $urandom_range(1, 5);
                repeat (k) begin
                    if (pick_span(start, lo, hi)) begin
                        queue_op(span_act(), lo, hi, rand_val());
                        made++;
                    end
                end
            end else if (n != 0 && pick < 70) begin
                if (pick_span(NO_HINT, lo, hi))
                    queue_op(span_act(), lo, hi, rand_val());
                else
                    queue_op(ACT_WRITE, $urandom_range(0, n - 1), $urandom_range(0, DEPTH - 1),
                             rand_val());
                made++;
            end else if (pick < 85) begin
                queue_op(ACT_WRITE, $urandom_range(0, DEPTH - 1), $urandom_range(0, DEPTH - 1),
                         rand_val());
                made++;
            end else begin
                queue_noise();
                made++;
            end
        end
    endtask

    // all beats sent and answered, then let a trailing rotate finish
    task automatic settle();
        do @(negedge aclk);
        while (pending.size() != 0 || s_valid || n_matched != n_expected);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_length(input logic [LEN_W-1:0] n);
        cfg_valid <= 1'b1;
        cfg_data  <= n;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        seq_len = n;
        @(negedge aclk);
    endtask

    initial begin
        foreach (loaded_pos[i]) loaded_pos[i] = 1'b0;

        // full length after reset: value extremes, ties, both ends of the store
        queue_op(ACT_WRITE, 0, DEPTH - 1, '0);
        queue_op(ACT_WRITE, 1, 0, '1);
        queue_op(ACT_WRITE, 2, DEPTH - 1, 30'h1555_5555);
        queue_op(ACT_WRITE, 3, 512, 30'h2AAA_AAAA);
        queue_op(ACT_WRITE, DEPTH - 3, 0, 30'd7);
        queue_op(ACT_WRITE, DEPTH - 2, 0, '1);
        queue_op(ACT_WRITE, DEPTH - 1, 0, 30'd7);
        queue_op(ACT_QUERY, 0, 3, '0);
        queue_op(ACT_QUERY, 1, 1, '0);
        queue_op(ACT_QUERY, DEPTH - 3, DEPTH - 1, '0);
        queue_op(ACT_ROTATE, 0, 3, '0);
        queue_op(ACT_QUERY, 0, 0, '0);
        queue_op(ACT_ROTATE, 1, 1, '0);
        queue_op(ACT_QUERY, 3, 2, '0);
        queue_op(ACT_ROTATE, 2, 1, '0);
        queue_op(ACT_NONE, DEPTH - 1, DEPTH - 1, '1);
        queue_op(ACT_ROTATE, DEPTH - 3, DEPTH - 1, '0);
        queue_op(ACT_QUERY, DEPTH - 2, DEPTH - 1, '0);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        gen_random(90);

        // short length: right end clipped, write and span past the end
        settle();
        set_length(11'd3);
        queue_op(ACT_QUERY, 0, DEPTH - 1, '0);
        queue_op(ACT_ROTATE, 1, DEPTH - 1, '0);
        queue_op(ACT_QUERY, 1, 2, '0);
        queue_op(ACT_WRITE, 3, 0, 30'd5);
        queue_op(ACT_QUERY, 3, 3, '0);

        // zero length: every span empty
        settle();
        set_length(11'd0);
        queue_op(ACT_QUERY, 0, 0, '0);
        queue_op(ACT_ROTATE, 0, DEPTH - 1, '0);
        queue_op(ACT_WRITE, 0, 0, '1);
        gen_random(10);

        // above the depth, stored values kept across length changes
        settle();
        set_length(11'h7FF);
        queue_op(ACT_QUERY, 0, 3, '0);
        queue_op(ACT_QUERY, DEPTH - 3, DEPTH - 1, '0);
        gen_random(110);

        settle();
        set_length(11'd1);
        gen_random(60);

        settle();
        set_length(LEN_RESET);
        gen_random(110);

        repeat (3) begin
            settle();
            set_length(LEN_W'($urandom_range(2, DEPTH - 1)));
            gen_random(70);
        end

        settle();
        if (n_fail == 0 && expected_mins.size() == 0)
            $display("PASS rotating_range_min_store");
        else
            $display("FAIL rotating_range_min_store");
        $finish;
    end

endmodule
